// ----- rtl/etps_pkg.sv -----
// shared types, register map and sine table helpers for the tone and pcm source
`default_nettype none
package etps_pkg;

  // register indexes on the write port
  localparam logic [2:0] REG_SOURCE_MODE    = 3'd0;
  localparam logic [2:0] REG_PHASE_STEP     = 3'd1;
  localparam logic [2:0] REG_BURST_LENGTH   = 3'd2;
  localparam logic [2:0] REG_ATTACK_LENGTH  = 3'd3;
  localparam logic [2:0] REG_RELEASE_LENGTH = 3'd4;
  localparam logic [2:0] REG_ATTACK_STEP    = 3'd5;
  localparam logic [2:0] REG_RELEASE_STEP   = 3'd6;
  localparam logic [2:0] REG_OUTPUT_GAIN    = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // source modes, the spare code acts as silence
  localparam logic [1:0] MODE_TONE    = 2'd0;
  localparam logic [1:0] MODE_PCM     = 2'd1;
  localparam logic [1:0] MODE_SILENCE = 2'd2;

  // what the back end does with a request
  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_TONE = 2'd1;
  localparam logic [1:0] KIND_PCM  = 2'd2;

  // envelope segment
  localparam logic [1:0] ENV_FULL    = 2'd0;
  localparam logic [1:0] ENV_ATTACK  = 2'd1;
  localparam logic [1:0] ENV_RELEASE = 2'd2;

  localparam logic [15:0] Q15_ONE = 16'h8000;
  localparam int RAMP_W = 12;

  typedef struct packed {
    logic [1:0]  source_mode;
    logic [31:0] phase_step;
    logic [19:0] burst_length;
    logic [11:0] attack_length;
    logic [11:0] release_length;
    logic [15:0] attack_step;
    logic [15:0] release_step;
    logic [15:0] output_gain;
  } etps_cfg_t;

  localparam etps_cfg_t CFG_RESET = '{
    source_mode:    2'd0,
    phase_step:     32'd93639233,
    burst_length:   20'd2040,
    attack_length:  12'd240,
    release_length: 12'd300,
    attack_step:    16'd137,
    release_step:   16'd109,
    output_gain:    16'd32768
  };

  typedef struct packed {
    logic               active;
    logic               last;
    logic [1:0]         kind;
    logic [1:0]         env_sel;
    logic [RAMP_W-1:0]  env_opnd;
    logic [31:0]        phase;
    logic signed [15:0] pcm;
  } etps_item_t;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SERIES_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                    64'd110, 64'd156, 64'd210};

  function automatic logic [15:0] lim_q15(input logic [15:0] v);
    lim_q15 = (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

  // rounded 32767*sin(x), x in q30 radians, taylor series to the fifteenth power
  function automatic logic [15:0] quarter_sine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          s;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[k];
      if ((k % 2) == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    v = ((unsigned'(s) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    quarter_sine = v[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/etps_front.sv -----
// front end: takes sample ticks, keeps burst count and phase, classifies each tick
`default_nettype none
module etps_front #(
  parameter int COUNT_WIDTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire etps_pkg::etps_cfg_t      cfg,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic                     in_restart,
  input  wire logic signed [15:0]       in_pcm,
  output logic                          push_valid,
  input  wire logic                     push_ready,
  output etps_pkg::etps_item_t          push_item
);

  localparam int CMP_W = (COUNT_WIDTH > 20) ? COUNT_WIDTH : 20;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [31:0]            phase_r, phase_nxt;

  logic [COUNT_WIDTH-1:0] n;
  logic [31:0]            ph;
  logic [CMP_W-1:0]       n_ext, bl_ext, remain;
  logic                   active;
  logic                   accept;

  assign in_tready = push_ready;
  assign accept    = in_tvalid && push_ready;

  always_comb begin
    n      = in_restart ? '0 : count_r;
    ph     = in_restart ? '0 : phase_r;
    n_ext  = CMP_W'(n);
    bl_ext = CMP_W'(cfg.burst_length);
    remain = bl_ext - n_ext;
    active = n_ext < bl_ext;

    push_item          = '0;
    push_item.active   = active;
    push_item.last     = active && (n_ext == (bl_ext - CMP_W'(1)));
    push_item.phase    = ph;
    push_item.pcm      = in_pcm;
    push_item.env_sel  = etps_pkg::ENV_FULL;
    push_item.env_opnd = '0;
    if (n_ext < CMP_W'(cfg.attack_length)) begin
      push_item.env_sel  = etps_pkg::ENV_ATTACK;
      push_item.env_opnd = etps_pkg::RAMP_W'(n_ext);
    end else if (remain < CMP_W'(cfg.release_length)) begin
      push_item.env_sel  = etps_pkg::ENV_RELEASE;
      push_item.env_opnd = etps_pkg::RAMP_W'(remain);
    end
    if (!active) begin
      push_item.kind = etps_pkg::KIND_ZERO;
    end else if (cfg.source_mode == etps_pkg::MODE_TONE) begin
      push_item.kind = etps_pkg::KIND_TONE;
    end else if (cfg.source_mode == etps_pkg::MODE_PCM) begin
      push_item.kind = etps_pkg::KIND_PCM;
    end else begin
      push_item.kind = etps_pkg::KIND_ZERO;
    end

    count_nxt = count_r;
    phase_nxt = phase_r;
    if (accept) begin
      count_nxt = active ? (n + COUNT_WIDTH'(1)) : n;
      phase_nxt = active ? (ph + cfg.phase_step) : ph;
    end
  end

  assign push_valid = in_tvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= '0;
    end else begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/etps_queue.sv -----
// two-entry request queue between the front and back ends
`default_nettype none
module etps_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_valid,
  output logic                      wr_ready,
  input  wire etps_pkg::etps_item_t wr_item,
  output logic                      rd_valid,
  input  wire logic                 rd_ready,
  output etps_pkg::etps_item_t      rd_item
);

  etps_pkg::etps_item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_item  = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/etps_back.sv -----
// back end: sine rom, envelope and gain through one shared multiplier, output register
`default_nettype none
module etps_back #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire etps_pkg::etps_cfg_t  cfg,
  input  wire logic                 rd_valid,
  output logic                      rd_ready,
  input  wire etps_pkg::etps_item_t rd_item,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic signed [15:0]        out_sample,
  output logic                      out_last,
  output logic                      out_active
);

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ENV  = 2'd1;
  localparam logic [1:0] S_MIX  = 2'd2;
  localparam logic [1:0] S_GAIN = 2'd3;

  // sine rom contents, built at elaboration from quadrant symmetry
  logic signed [15:0] rom_tab [SINE_TABLE_DEPTH];

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint unsigned T   = 64'(4 * gi);
    localparam longint unsigned Q   = T / SINE_TABLE_DEPTH;
    localparam longint unsigned R   = T % SINE_TABLE_DEPTH;
    localparam longint unsigned ARG = ((Q % 2) == 1) ? (SINE_TABLE_DEPTH - R) : R;
    localparam longint unsigned X   = (etps_pkg::HALF_PI_Q30 * ARG) / SINE_TABLE_DEPTH;
    localparam logic [15:0]     MAG = etps_pkg::quarter_sine(X);
    assign rom_tab[gi] = (((Q / 2) % 2) == 1) ? -$signed(MAG) : $signed(MAG);
  end

  logic [1:0]              state_r, state_nxt;
  logic                    active_r, last_r;
  logic [1:0]              kind_r, env_sel_r;
  logic [etps_pkg::RAMP_W-1:0] env_opnd_r;
  logic signed [15:0]      pcm_r;
  logic [ADDR_W-1:0]       rom_addr_r;
  logic signed [15:0]      rom_q_r;
  logic [15:0]             env_r;
  logic signed [15:0]      v_r;

  logic                    out_valid_r;
  logic signed [15:0]      out_sample_r;
  logic                    out_last_r, out_active_r;

  logic [63:0]             addr_prod;
  logic signed [16:0]      mul_a, mul_b;
  logic signed [33:0]      prod;
  logic [33:0]             prod_mag;
  logic [15:0]             env_calc;
  logic signed [15:0]      trunc_val;
  logic                    pop, load_out;

  assign pop       = (state_r == S_IDLE) && rd_valid;
  assign rd_ready  = (state_r == S_IDLE);
  assign load_out  = (state_r == S_GAIN) && (!out_valid_r || out_tready);
  assign addr_prod = 64'(rd_item.phase) * 64'(SINE_TABLE_DEPTH);

  // shared multiplier, operands picked by the sequencer state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ENV: begin
        mul_a = 17'(env_opnd_r);
        mul_b = (env_sel_r == etps_pkg::ENV_ATTACK)
              ? $signed({1'b0, etps_pkg::lim_q15(cfg.attack_step)})
              : $signed({1'b0, etps_pkg::lim_q15(cfg.release_step)});
      end
      S_MIX: begin
        mul_a = 17'(rom_q_r);
        mul_b = $signed({1'b0, env_r});
      end
      S_GAIN: begin
        if (kind_r == etps_pkg::KIND_TONE) begin
          mul_a = 17'(v_r);
        end else if (kind_r == etps_pkg::KIND_PCM) begin
          mul_a = 17'(pcm_r);
        end
        mul_b = $signed({1'b0, etps_pkg::lim_q15(cfg.output_gain)});
      end
      S_IDLE: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_mag = prod[33] ? 34'(-prod) : 34'(prod);

  always_comb begin
    if (env_sel_r == etps_pkg::ENV_FULL) begin
      env_calc = etps_pkg::Q15_ONE;
    end else if (prod > 34'sd32768) begin
      env_calc = etps_pkg::Q15_ONE;
    end else begin
      env_calc = prod[15:0];
    end
    // shift toward zero for the rom times envelope product
    trunc_val = prod[33] ? -$signed(prod_mag[30:15]) : $signed(prod_mag[30:15]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (rd_valid) state_nxt = S_ENV;
      S_ENV:  state_nxt = S_MIX;
      S_MIX:  state_nxt = S_GAIN;
      S_GAIN: if (load_out) state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      active_r   <= rd_item.active;
      last_r     <= rd_item.last;
      kind_r     <= rd_item.kind;
      env_sel_r  <= rd_item.env_sel;
      env_opnd_r <= rd_item.env_opnd;
      pcm_r      <= rd_item.pcm;
      rom_addr_r <= addr_prod[32 +: ADDR_W];
    end
    if (state_r == S_ENV) begin
      env_r   <= env_calc;
      rom_q_r <= rom_tab[rom_addr_r];
    end
    if (state_r == S_MIX) begin
      v_r <= trunc_val;
    end
    if (load_out) begin
      // gain product floors, an arithmetic shift
      out_sample_r <= prod[30:15];
      out_last_r   <= last_r;
      out_active_r <= active_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;
  assign out_active = out_active_r;

endmodule
`default_nettype wire

// ----- rtl/enveloped_tone_and_pcm_source.sv -----
// Enveloped tone and pcm source. Every input tick yields one stereo sample.
// A front end keeps the burst count and phase accumulator and classifies the
// tick; a two-entry queue carries it to a back end that reads the sine rom and
// applies envelope and gain. In the back end each sample goes through queue pop,
// envelope, rom times envelope and gain, as the single 17x17 multiplier is shared
// by those three products; the back end pops a new sample only once the last is
// in the output register. Configuration is written through cfg_we/cfg_index/
// cfg_wdata by the user only while no sample is in flight; the block does not enforce it.
`default_nettype none
module enveloped_tone_and_pcm_source #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COUNT_WIDTH      = 20
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [15:0]                        in_tdata,  // [15:0] pcm_sample
  input  wire logic                               in_tuser,  // restart
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [31:0]                             out_tdata, // [15:0] left, [31:16] right
  output logic                                    out_tlast,
  output logic                                    out_tuser, // active
  input  wire logic                               cfg_we,
  input  wire logic [etps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [etps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  etps_pkg::etps_cfg_t  cfg_r, cfg_nxt;
  etps_pkg::etps_item_t push_item, pop_item;
  logic                 push_valid, push_ready, pop_valid, pop_ready;
  logic signed [15:0]   sample;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        etps_pkg::REG_SOURCE_MODE:    cfg_nxt.source_mode    = cfg_wdata[1:0];
        etps_pkg::REG_PHASE_STEP:     cfg_nxt.phase_step     = cfg_wdata[31:0];
        etps_pkg::REG_BURST_LENGTH:   cfg_nxt.burst_length   = cfg_wdata[19:0];
        etps_pkg::REG_ATTACK_LENGTH:  cfg_nxt.attack_length  = cfg_wdata[11:0];
        etps_pkg::REG_RELEASE_LENGTH: cfg_nxt.release_length = cfg_wdata[11:0];
        etps_pkg::REG_ATTACK_STEP:    cfg_nxt.attack_step    = cfg_wdata[15:0];
        etps_pkg::REG_RELEASE_STEP:   cfg_nxt.release_step   = cfg_wdata[15:0];
        etps_pkg::REG_OUTPUT_GAIN:    cfg_nxt.output_gain    = cfg_wdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= etps_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  etps_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_restart (in_tuser),
    .in_pcm     ($signed(in_tdata)),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  etps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  etps_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .rd_valid   (pop_valid),
    .rd_ready   (pop_ready),
    .rd_item    (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_sample (sample),
    .out_last   (out_tlast),
    .out_active (out_tuser)
  );

  // mono copied to both channels
  assign out_tdata = {sample, sample};

endmodule
`default_nettype wire

// ----- rtl/etps_checker.sv -----
// port-level checks for the tone and pcm source, bound to the top level
`default_nettype none
module etps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
                                  && $stable(out_tuser))
    else $error("result changed while stalled");

  a_stereo_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] == out_tdata[31:16]))
    else $error("left and right differ");

  a_last_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last flagged outside a burst");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata == 32'd0))
    else $error("nonzero sample after the burst");

endmodule

bind enveloped_tone_and_pcm_source etps_checker u_etps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire
